// ===== design/running_mean_variance_stats_unit_defines.svh =====
// ----------------------------------------------------------------------------
// running_mean_variance_stats_unit_defines
// Assertion macros shared by the statistics unit RTL.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_STATS_UNIT_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_STATS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// plain property check on the unit clock
`define RMVS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rmvs assertion failed");
// same-cycle implication
`define RMVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmvs implication failed");
// next-cycle implication
`define RMVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmvs next-cycle implication failed");
`else
`define RMVS_ASSERT(lbl, prop)
`define RMVS_ASSERT_IMP(lbl, ante, cons)
`define RMVS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== design/rmvs_pkg.sv =====
// ----------------------------------------------------------------------------
// rmvs_pkg
// Types and fixed constants of the running mean / variance statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmvs_pkg;

  // working width of the shared unit accumulator (d squared needs 65 bits)
  localparam int NUM_W      = 66;
  localparam int MEAN_W     = 33;
  localparam int M2_W       = 64;
  localparam int RES_FRAC   = 16;
  localparam int SQRT_IN_W  = 32;
  localparam int SQRT_STEPS = 16;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL,
    OP_SQRT
  } unit_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_STEP,
    S_MUL,
    S_TERM,
    S_VAR,
    S_SQRT,
    S_ZF,
    S_OF,
    S_FIN
  } state_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

endpackage

`default_nettype wire

// ===== design/rmvs_unit.sv =====
// ----------------------------------------------------------------------------
// rmvs_unit
// Shared iterative arithmetic unit: restoring divide, shift-add multiply and
// digit-by-digit square root, one bit (or one root digit) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmvs_unit #(
  parameter int DIV_W = 34
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rmvs_pkg::unit_req_t       req_i,
  input  wire logic [rmvs_pkg::NUM_W-1:0] a_i,
  input  wire logic [DIV_W-1:0]          b_i,
  output rmvs_pkg::unit_rsp_t            rsp_o,
  output logic [rmvs_pkg::NUM_W-1:0]     quo_o,
  output logic [DIV_W-1:0]               rem_o,
  output logic [rmvs_pkg::SQRT_STEPS-1:0] root_o
);
  import rmvs_pkg::*;

  localparam int RW    = DIV_W + 1;
  localparam int CNT_W = $clog2(NUM_W + RW + 1);

  logic                  busy_q, done_q;
  unit_op_e              op_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [NUM_W-1:0]      acc_q, acc_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic [DIV_W-1:0]      opb_q;
  logic [SQRT_STEPS-1:0] root_q, root_d;

  logic [RW-1:0]    div_sh;
  logic [RW:0]      div_sub;
  logic [NUM_W-1:0] mul_sum;
  logic [RW-1:0]    sq_sh, sq_trial;
  logic [RW:0]      sq_sub;

  // one iteration step of each operation
  always_comb begin
    div_sh   = {rem_q[RW-2:0], acc_q[NUM_W-1]};
    div_sub  = {1'b0, div_sh} - {2'b00, opb_q};
    mul_sum  = {acc_q[NUM_W-2:0], 1'b0} + (rem_q[RW-1] ? NUM_W'(opb_q) : '0);
    sq_sh    = {rem_q[RW-3:0], acc_q[SQRT_IN_W-1 -: 2]};
    sq_trial = RW'({root_q, 2'b01});
    sq_sub   = {1'b0, sq_sh} - {1'b0, sq_trial};
    acc_d    = acc_q;
    rem_d    = rem_q;
    root_d   = root_q;
    case (op_q)
      OP_DIV: begin
        acc_d = {acc_q[NUM_W-2:0], ~div_sub[RW]};
        rem_d = div_sub[RW] ? div_sh : div_sub[RW-1:0];
      end
      OP_MUL: begin
        acc_d = mul_sum;
        rem_d = {rem_q[RW-2:0], 1'b0};
      end
      OP_SQRT: begin
        acc_d  = {acc_q[NUM_W-3:0], 2'b00};
        rem_d  = sq_sub[RW] ? sq_sh : sq_sub[RW-1:0];
        root_d = {root_q[SQRT_STEPS-2:0], ~sq_sub[RW]};
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  // control: load on start, count down iterations, pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        case (req_i.op)
          OP_DIV:  cnt_q <= CNT_W'(NUM_W - 1);
          OP_MUL:  cnt_q <= CNT_W'(RW - 1);
          OP_SQRT: cnt_q <= CNT_W'(SQRT_STEPS - 1);
          default: cnt_q <= '0;
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      acc_q  <= (req_i.op == OP_MUL) ? '0 : a_i;
      rem_q  <= (req_i.op == OP_MUL) ? a_i[RW-1:0] : '0;
      opb_q  <= b_i;
      root_q <= '0;
    end else if (busy_q) begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quo_o      = acc_q;
  assign rem_o      = rem_q[DIV_W-1:0];
  assign root_o     = root_q;

endmodule

`default_nettype wire

// ===== design/running_mean_variance_stats_unit.sv =====
// Operation: every sample runs through the shared bit-serial unit in turn:
//   five 66-step divides, a 35-step multiply and a root (the first sample
//   skips the variance divide and root; a full count skips the mean and M2 update).
// Input: one sample at a time; a new sample is taken in the cycle
//   after the result has entered the output register.
// Reset: asynchronous, active low; clears count, mean, M2 and hit counters.
// ----------------------------------------------------------------------------
// running_mean_variance_stats_unit
// Welford running mean / sample variance / std deviation with 0 and 1 shares.
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_mean_variance_stats_unit_defines.svh"

module running_mean_variance_stats_unit #(
  parameter int COUNT_BITS       = 32,
  parameter int SAMPLE_FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [SAMPLE_FRAC_BITS:0] sample_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [31:0]                    sample_count_o,
  output logic [16:0]                    running_mean_o,
  output logic [15:0]                    sample_variance_o,
  output logic [15:0]                    std_dev_o,
  output logic [16:0]                    zero_fraction_o,
  output logic [16:0]                    one_fraction_o,
  output logic                           variance_valid_o,
  output logic                           saturated_o
);
  import rmvs_pkg::*;

  localparam int CB  = COUNT_BITS;
  localparam int SW  = SAMPLE_FRAC_BITS + 1;
  localparam int DW  = (CB > 34) ? CB : 34;
  localparam int CW  = (CB > 32) ? CB : 32;
  localparam logic [SW-1:0] ONE = SW'(1) << SAMPLE_FRAC_BITS;

  state_e state_q, state_d;
  logic   issued_q;

  logic [SW-1:0]        samp_q;
  logic [CB-1:0]        count_q, zhits_q, ohits_q;
  logic [MEAN_W-1:0]    mean_q, d_q, step_q;
  logic                 up_q, sat_q;
  logic [M2_W-1:0]      m2_q;
  logic [64:0]          sq_q;
  logic [SQRT_IN_W-1:0] v_q;
  logic [15:0]          var_q, sd_q;
  logic [16:0]          zf_q, of_q;

  unit_req_t             req;
  unit_rsp_t             rsp;
  logic [NUM_W-1:0]      a_op, quo;
  logic [DW-1:0]         b_op, rem;
  logic [SQRT_STEPS-1:0] root;

  logic [CB-1:0]     n_new;
  logic              cnt_full, skip;
  logic [SW-1:0]     x_cl;
  logic [MEAN_W-1:0] x32;
  logic              in_acc, out_load;

  rmvs_unit #(.DIV_W(DW)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (a_op),
    .b_i    (b_op),
    .rsp_o  (rsp),
    .quo_o  (quo),
    .rem_o  (rem),
    .root_o (root)
  );

  // sample clamp and common values
  assign n_new    = count_q + 1'b1;
  assign cnt_full = &count_q;
  assign x_cl     = (samp_q > ONE) ? ONE : samp_q;
  assign x32      = MEAN_W'(x_cl) << (32 - SAMPLE_FRAC_BITS);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_FIN) && (!out_valid_o || !out_stall_i);

  // operation skipped when the count makes it trivial
  always_comb begin
    case (state_q)
      S_VAR:       skip = (count_q < CB'(2));
      S_ZF, S_OF:  skip = (count_q == '0);
      default:     skip = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_PREP;
      S_PREP: state_d = cnt_full ? S_VAR : S_STEP;
      S_STEP: if (rsp.done) state_d = S_MUL;
      S_MUL:  if (rsp.done) state_d = S_TERM;
      S_TERM: if (rsp.done) state_d = S_VAR;
      S_VAR: begin
        if (skip) state_d = S_ZF;
        else if (rsp.done) state_d = S_SQRT;
      end
      S_SQRT: if (rsp.done) state_d = S_ZF;
      S_ZF: begin
        if (skip) state_d = S_FIN;
        else if (rsp.done) state_d = S_OF;
      end
      S_OF:   if (rsp.done) state_d = S_FIN;
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // unit requests and operands
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_DIV;
    a_op      = '0;
    b_op      = '0;
    case (state_q)
      S_STEP: begin
        req.start = 1'b1;
        a_op      = NUM_W'(d_q) + NUM_W'(n_new >> 1);
        b_op      = DW'(n_new);
      end
      S_MUL: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        a_op      = NUM_W'(d_q);
        b_op      = DW'(d_q);
      end
      S_TERM: begin
        req.start = 1'b1;
        a_op      = NUM_W'(sq_q);
        b_op      = DW'(n_new);
      end
      S_VAR: begin
        req.start = !skip;
        a_op      = NUM_W'(m2_q);
        b_op      = DW'(count_q - 1'b1);
      end
      S_SQRT: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
        a_op      = NUM_W'(v_q);
      end
      S_ZF: begin
        req.start = !skip;
        a_op      = NUM_W'(zhits_q) << RES_FRAC;
        b_op      = DW'(count_q);
      end
      S_OF: begin
        req.start = !skip;
        a_op      = NUM_W'(ohits_q) << RES_FRAC;
        b_op      = DW'(count_q);
      end
      default: req.start = 1'b0;
    endcase
    req.start = req.start && !issued_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp.done) issued_q <= 1'b0;
      else if (req.start) issued_q <= 1'b1;
    end
  end

  // statistics state
  logic [NUM_W-1:0] cceil, tdiff;
  logic [M2_W:0]    m2_sum;
  logic [31:0]      v_cap;
  logic [32:0]      v_rnd;
  logic [16:0]      share_q;
  logic [DW:0]      rem2;

  always_comb begin
    cceil   = quo + NUM_W'(rem != '0);
    tdiff   = NUM_W'(sq_q) - cceil;
    m2_sum  = {1'b0, m2_q} + (M2_W + 1)'(tdiff[64:32]);
    v_cap   = (|quo[NUM_W-1:32]) ? '1 : quo[31:0];
    v_rnd   = {1'b0, v_cap} + 33'(1 << (RES_FRAC - 1));
    rem2    = {rem, 1'b0};
    share_q = quo[16:0] + 17'(rem2 >= (DW + 1)'(count_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      zhits_q <= '0;
      ohits_q <= '0;
      mean_q  <= '0;
      m2_q    <= '0;
    end else if (state_q == S_PREP && !cnt_full) begin
      if (x_cl == '0) zhits_q <= zhits_q + 1'b1;
      else if (x_cl == ONE) ohits_q <= ohits_q + 1'b1;
    end else if (state_q == S_TERM && rsp.done) begin
      mean_q  <= up_q ? mean_q + step_q : mean_q - step_q;
      m2_q    <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
      count_q <= n_new;
    end
  end

  // per-sample working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) samp_q <= sample_i;
    if (state_q == S_PREP) begin
      sat_q <= cnt_full;
      up_q  <= (x32 >= mean_q);
      d_q   <= (x32 >= mean_q) ? x32 - mean_q : mean_q - x32;
    end
    if (rsp.done) begin
      case (state_q)
        S_STEP: step_q <= quo[MEAN_W-1:0];
        S_MUL:  sq_q   <= quo[64:0];
        S_VAR: begin
          v_q   <= v_cap;
          var_q <= v_rnd[32] ? '1 : v_rnd[31:16];
        end
        S_SQRT: sd_q <= root;
        S_ZF:   zf_q <= share_q;
        S_OF:   of_q <= share_q;
        default: sd_q <= sd_q;
      endcase
    end
    if (state_q == S_VAR && skip) begin
      var_q <= '0;
      sd_q  <= '0;
    end
    if (state_q == S_ZF && skip) begin
      zf_q <= '0;
      of_q <= '0;
    end
  end

  // output register
  logic [CW-1:0] cnt_ext;
  logic [33:0]   mean_rnd;
  assign cnt_ext  = CW'(count_q);
  assign mean_rnd = {1'b0, mean_q} + 34'(1 << (RES_FRAC - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_count_o    <= (cnt_ext > CW'(32'hFFFF_FFFF)) ? '1 : cnt_ext[31:0];
      running_mean_o    <= mean_rnd[32:16];
      sample_variance_o <= var_q;
      std_dev_o         <= sd_q;
      zero_fraction_o   <= zf_q;
      one_fraction_o    <= of_q;
      variance_valid_o  <= (count_q >= CB'(2));
      saturated_o       <= sat_q;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // checks
  `RMVS_ASSERT_NXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o)
  `RMVS_ASSERT_IMP(a_done_was_issued, rsp.done, issued_q)
  `RMVS_ASSERT_IMP(a_invalid_var_zero, out_valid_o && !variance_valid_o,
                   sample_variance_o == '0 && std_dev_o == '0)
  `RMVS_ASSERT(a_mean_range, !out_valid_o || running_mean_o <= 17'h10000)

endmodule

`default_nettype wire
